[hdl/battery_voltage_moving_average_core_macros.svh]
// assertion macros for the battery voltage moving-average core
// no dependencies; included by the top level
`ifndef BATTERY_VOLTAGE_MOVING_AVERAGE_CORE_MACROS_SVH
`define BATTERY_VOLTAGE_MOVING_AVERAGE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define BVMA_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bvma check failed");
// consequence holds in the cycle after the antecedent
`define BVMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvma check failed");
`else
`define BVMA_ASSERT(label, clk, rst_n, cond)
`define BVMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/bvma_pkg.sv]
// shared constants, types and codes of the battery voltage moving-average core
// no dependencies
package bvma_pkg;

    localparam int ADC_BITS   = 10;
    localparam int WINDOW_MAX = 32;

    // fixed field widths
    localparam int SAMPLE_W   = 10;
    localparam int AVG_W      = 10;
    localparam int MV_W       = 16;
    localparam int OFFSET_W   = 11;
    localparam int CFG_WIN_W  = 6;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int ADC_MAX   = (1 << ADC_BITS) - 1;
    localparam int SUM_MAX   = WINDOW_MAX * ADC_MAX;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int PTR_W     = $clog2(WINDOW_MAX);
    localparam int WIN_W     = $clog2(WINDOW_MAX + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int WIN_RESET    = 20;
    localparam int OFFSET_RESET = 200;

    // millivolt scaling: avg * MV_NUM / MV_DEN by reciprocal plus one correction
    localparam longint MV_NUM   = 735000;
    localparam longint MV_DEN   = 47 * ADC_MAX;
    localparam int     MV_SHIFT = 20;
    localparam longint MV_MUL   = (MV_NUM << MV_SHIFT) / MV_DEN;
    localparam int     MV_MUL_W = $clog2(MV_MUL + 1);
    localparam int     MV_P_W   = $clog2(longint'(ADC_MAX) * MV_NUM + 1);
    localparam int     MV_Q_W   = $clog2(longint'(ADC_MAX) * MV_NUM / MV_DEN + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 1'b0,
        CFG_OFFSET = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ADC_BITS-1:0] sample;
    } bvma_cmd_t;

    typedef struct packed {
        logic [PTR_W-1:0] pos;
        logic             out_load;
        logic             res_full;
    } bvma_status_t;

endpackage

[hdl/bvma_front.sv]
// input side: accepts items, decodes the kind and queues commands for the back end
// depends on bvma_pkg
module bvma_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          kind,
    input  logic [bvma_pkg::SAMPLE_W-1:0] sample,
    output logic                          cmd_valid,
    output bvma_pkg::bvma_cmd_t           cmd,
    input  logic                          cmd_pop
);
    import bvma_pkg::*;

    bvma_cmd_t              fifo_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0]   count_reg, count_next;
    logic                   wr_en;
    logic                   rd_en;
    bvma_cmd_t              new_cmd;

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_mem[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    always_comb
    begin
        new_cmd.op     = kind ? OP_RESTART : OP_SAMPLE;
        new_cmd.sample = sample[ADC_BITS-1:0];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[hdl/bvma_div.sv]
// restoring divider, one quotient bit per cycle: running sum over window size
// depends on bvma_pkg
module bvma_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bvma_pkg::SUM_W-1:0] dividend,
    input  logic [bvma_pkg::WIN_W-1:0] divisor,
    output logic                       done,
    output logic [bvma_pkg::SUM_W-1:0] quotient
);
    import bvma_pkg::*;

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [WIN_W-1:0]     rem_reg, rem_next;
    logic [WIN_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIN_W:0]       shifted;
    logic [WIN_W:0]       diff;

    assign shifted  = {rem_reg, quo_reg[SUM_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[WIN_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIN_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

[hdl/bvma_back.sv]
// back end: sample ring, running sum, averaging and millivolt conversion, result register
// depends on bvma_pkg and bvma_div
module bvma_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  bvma_pkg::bvma_cmd_t                  cmd,
    output logic                                 cmd_pop,
    input  logic [bvma_pkg::WIN_W-1:0]           window,
    input  logic signed [bvma_pkg::OFFSET_W-1:0] offset,
    input  logic                                 win_wr,
    input  logic                                 res_pop,
    output logic                                 res_valid,
    output logic [bvma_pkg::AVG_W-1:0]           average,
    output logic signed [bvma_pkg::MV_W-1:0]     millivolts,
    output bvma_pkg::bvma_status_t               status
);
    import bvma_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FILL = 8'b0000_0010,
        S_UPD  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MULA = 8'b0001_0000,
        S_MULB = 8'b0010_0000,
        S_MULC = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    localparam logic [MV_MUL_W-1:0] MV_MUL_C = MV_MUL_W'(MV_MUL);
    localparam logic [MV_P_W-1:0]   MV_NUM_C = MV_P_W'(MV_NUM);
    localparam logic [MV_P_W-1:0]   MV_DEN_C = MV_P_W'(MV_DEN);

    logic [ADC_BITS-1:0] ring_mem [WINDOW_MAX];
    logic [ADC_BITS-1:0] rdata_reg;

    state_t              state_reg, state_next;
    logic [WINDOW_MAX-1:0] valid_reg, valid_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PTR_W-1:0]    pos_reg, pos_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic                res_valid_reg, res_valid_next;

    logic [ADC_BITS-1:0] sample_reg, sample_next;
    logic [ADC_BITS-1:0] avg_reg, avg_next;
    logic [MV_Q_W-1:0]   q0_reg, q0_next;
    logic [MV_P_W-1:0]   qd_reg, qd_next;
    logic [MV_P_W-1:0]   p_reg, p_next;
    logic [AVG_W-1:0]    avg_out_reg;
    logic signed [MV_W-1:0] mv_out_reg;

    logic                mem_we;
    logic [PTR_W-1:0]    mem_wa;
    logic [PTR_W-1:0]    pos_eff;
    logic [WIN_W-1:0]    win_m1;
    logic [ADC_BITS+WIN_W-1:0] fill_prod;
    logic [ADC_BITS-1:0] old_val;
    logic [SUM_W-1:0]    sum_sub;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_upd;
    logic [PTR_W-1:0]    pos_wrap;
    logic [AVG_W+MV_MUL_W-1:0] prod_a;
    logic [MV_P_W-1:0]   rem_fix;
    logic [MV_Q_W-1:0]   q_fin;
    logic signed [MV_W-1:0] mv_fin;
    logic                out_load;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quo;

    bvma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_upd),
        .divisor  (window),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign win_m1    = window - 1'b1;
    assign pos_eff   = ({1'b0, pos_reg} >= window) ? '0 : pos_reg;
    assign fill_prod = (ADC_BITS+WIN_W)'(cmd.sample) * (ADC_BITS+WIN_W)'(window);

    // entries never written since reset read as zero
    assign old_val  = valid_reg[pos_reg] ? rdata_reg : '0;
    assign sum_sub  = (sum_reg >= SUM_W'(old_val)) ? sum_reg - SUM_W'(old_val) : '0;
    assign sum_add  = {1'b0, sum_sub} + (SUM_W+1)'(sample_reg);
    assign sum_upd  = (sum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : sum_add[SUM_W-1:0];
    assign pos_wrap = ({1'b0, pos_reg} == win_m1) ? '0 : pos_reg + 1'b1;

    // reciprocal estimate is low by at most one; the remainder check fixes it
    assign prod_a  = (AVG_W+MV_MUL_W)'(avg_reg) * (AVG_W+MV_MUL_W)'(MV_MUL_C);
    assign rem_fix = p_reg - qd_reg;
    assign q_fin   = (rem_fix >= MV_DEN_C) ? q0_reg + 1'b1 : q0_reg;
    assign mv_fin  = $signed(MV_W'(q_fin)) + $signed({{(MV_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        sample_next = sample_reg;
        avg_next    = avg_reg;
        q0_next     = q0_reg;
        qd_next     = qd_reg;
        p_next      = p_reg;
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = pos_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    sample_next = cmd.sample;
                    if (cmd.op == OP_RESTART)
                    begin
                        sum_next   = fill_prod[SUM_W-1:0];
                        pos_next   = '0;
                        idx_next   = '0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        pos_next   = pos_eff;
                        state_next = S_UPD;
                    end
                end
            end
            S_FILL:
            begin
                mem_we              = 1'b1;
                mem_wa              = idx_reg;
                valid_next[idx_reg] = 1'b1;
                if ({1'b0, idx_reg} == win_m1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_UPD:
            begin
                mem_we              = 1'b1;
                mem_wa              = pos_reg;
                valid_next[pos_reg] = 1'b1;
                sum_next            = sum_upd;
                pos_next            = pos_wrap;
                div_start           = 1'b1;
                state_next          = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = (div_quo > SUM_W'(ADC_MAX)) ? ADC_BITS'(ADC_MAX)
                                                             : div_quo[ADC_BITS-1:0];
                    state_next = S_MULA;
                end
            end
            S_MULA:
            begin
                q0_next    = prod_a[MV_SHIFT +: MV_Q_W];
                state_next = S_MULB;
            end
            S_MULB:
            begin
                qd_next    = MV_P_W'(q0_reg) * MV_DEN_C;
                state_next = S_MULC;
            end
            S_MULC:
            begin
                p_next     = MV_P_W'(avg_reg) * MV_NUM_C;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!res_valid_reg)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (win_wr)
        begin
            pos_next = '0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        avg_reg    <= avg_next;
        q0_reg     <= q0_next;
        qd_reg     <= qd_next;
        p_reg      <= p_next;
        if (out_load)
        begin
            avg_out_reg <= AVG_W'(avg_reg);
            mv_out_reg  <= mv_fin;
        end
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_wa] <= sample_reg;
        end
        rdata_reg <= ring_mem[pos_eff];
    end

    assign res_valid       = res_valid_reg;
    assign average         = avg_out_reg;
    assign millivolts      = mv_out_reg;
    assign status.pos      = pos_reg;
    assign status.out_load = out_load;
    assign status.res_full = res_valid_reg;

endmodule

[hdl/battery_voltage_moving_average_core.sv]
// Battery voltage moving-average core. Sample items (kind 0) replace the oldest
// entry of a ring of the last window_size samples and produce one result: the
// truncated mean in ADC counts and that mean in millivolts plus offset_mv.
// Restart items (kind 1) prefill the window with their sample and produce no
// result. A sample item's time in the back end is set mostly by
// the 15-step serial divider that forms sum / window; a restart fills
// the window with one ring write per cycle. A two-entry command queue
// takes new items while the back end works, and a result register holds the
// finished result until popped. The ring reads as zero after reset through
// per-entry valid bits, so no clearing pass is needed. Write window_size and
// offset_mv only while the core is idle, and send a restart after changing
// window_size.
// depends on bvma_pkg, bvma_front, bvma_back and the assertion macro header
`include "battery_voltage_moving_average_core_macros.svh"

module battery_voltage_moving_average_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 kind,
    input  logic [bvma_pkg::SAMPLE_W-1:0]        sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [bvma_pkg::AVG_W-1:0]           average,
    output logic signed [bvma_pkg::MV_W-1:0]     millivolts,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bvma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bvma_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bvma_pkg::*;

    logic [WIN_W-1:0]           win_reg, win_next;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;
    logic [CFG_WIN_W-1:0]       win_raw;
    logic                       cfg_wr;
    logic                       win_wr;
    logic                       cmd_valid;
    bvma_cmd_t                  cmd;
    logic                       cmd_pop;
    logic                       res_valid;
    logic                       res_pop;
    bvma_status_t               status;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign win_raw   = cfg_data[CFG_WIN_W-1:0];
    assign empty     = !res_valid;
    assign res_pop   = pop && res_valid;

    always_comb
    begin
        win_next    = win_reg;
        offset_next = offset_reg;
        win_wr      = 1'b0;
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_WINDOW:
                begin
                    win_wr = 1'b1;
                    if (win_raw == '0)
                    begin
                        win_next = WIN_W'(1);
                    end
                    else if (int'(win_raw) > WINDOW_MAX)
                    begin
                        win_next = WIN_W'(WINDOW_MAX);
                    end
                    else
                    begin
                        win_next = WIN_W'(win_raw);
                    end
                end
                CFG_OFFSET:
                begin
                    offset_next = $signed(cfg_data[OFFSET_W-1:0]);
                end
                default:
                begin
                    win_next = win_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= WIN_W'(WIN_RESET);
            offset_reg <= OFFSET_W'(OFFSET_RESET);
        end
        else
        begin
            win_reg    <= win_next;
            offset_reg <= offset_next;
        end
    end

    bvma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .sample    (sample),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    bvma_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .window     (win_reg),
        .offset     (offset_reg),
        .win_wr     (win_wr),
        .res_pop    (res_pop),
        .res_valid  (res_valid),
        .average    (average),
        .millivolts (millivolts),
        .status     (status)
    );

    // write position always inside the active window
    `BVMA_ASSERT(a_pos_in_window, clk, rst_n, ({1'b0, status.pos} < win_reg))
    // window register stays clamped
    `BVMA_ASSERT(a_win_range, clk, rst_n, (win_reg != '0) && (int'(win_reg) <= WINDOW_MAX))
    // a result is never loaded over one still waiting
    `BVMA_ASSERT(a_no_overwrite, clk, rst_n, !(status.out_load && status.res_full))
    // a loaded result shows on the result side next cycle
    `BVMA_ASSERT_NEXT(a_load_shows, clk, rst_n, status.out_load, !empty)

endmodule
